FILE: rtl/core/matrix4_inverse_adjugate_top_macros.svh
// Assertion macros used by the matrix inverse controller.
`ifndef MATRIX4_INVERSE_ADJUGATE_TOP_MACROS_SVH
`define MATRIX4_INVERSE_ADJUGATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mia assertion failed");
`define MIA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define MIA_ASSERT(lbl, prop)
`define MIA_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/mia_pkg.sv
// Shared types and constants for the 4x4 matrix inverse block.
`default_nettype none
package mia_pkg;

  localparam int WIDE_W = 64;
  localparam logic [WIDE_W-1:0] WIDE_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int THR_W = 31;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    BSEL_MEM  = 2'd0,
    BSEL_DACC = 2'd1,
    BSEL_TACC = 2'd2
  } bsel_e;

  typedef enum logic [1:0] {
    TGT_DACC = 2'd0,
    TGT_TACC = 2'd1,
    TGT_DET  = 2'd2
  } acc_tgt_e;

  typedef enum logic [1:0] {
    ACC_LOAD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_a;
    logic              ld_b;
    bsel_e             b_sel;
    logic              mul_pp;
    logic [1:0]        pp_idx;
    logic              mul_fin;
    logic              acc_en;
    acc_tgt_e          acc_tgt;
    acc_op_e           acc_op;
    logic              div_start;
    logic              div_neg;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic det_small;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/mia_datapath.sv
// Datapath: element store, shared multiplier, accumulators and divider.
`default_nettype none
module mia_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mia_pkg::dp_cmd_t        cmd_i,
  output mia_pkg::dp_sts_t             sts_o,
  input  wire logic [DATA_WIDTH-1:0]   element_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [mia_pkg::THR_W-1:0] cfg_data_i,
  output logic [DATA_WIDTH-1:0]        inv_o,
  output logic                         clip_o
);
  import mia_pkg::*;

  localparam int NUM_W = 62 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] LIM_POS = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] LIM_NEG = 64'd1 << (DATA_WIDTH - 1);
  localparam logic signed [64:0] POS_LIM = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] NEG_LIM = -POS_LIM;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // element store
  logic [DATA_WIDTH-1:0] mem_q [16];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [63:0]           rd_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= element_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  assign rd_ext = {{(64 - DATA_WIDTH){rdata_q[DATA_WIDTH-1]}}, rdata_q};

  // multiplier: four 32x32 partial products
  logic [63:0]  opa_q, ma_q, mb_q, prod_q, dacc_q, tacc_q, det_q;
  logic         pneg_q;
  logic [127:0] pacc_q;
  logic [63:0]  b_src, pp_prod, prod_d, acc_cur, acc_new;
  logic [31:0]  a_h, b_h;
  logic [127:0] pp_ext, pp_sh, rnd, rsh;
  logic [63:0]  rmag;
  logic signed [64:0] acc_sum, cur_s, prd_s;

  always_comb begin
    case (cmd_i.b_sel)
      BSEL_MEM:  b_src = rd_ext;
      BSEL_DACC: b_src = dacc_q;
      BSEL_TACC: b_src = tacc_q;
      default:   b_src = rd_ext;
    endcase
  end

  assign a_h     = cmd_i.pp_idx[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_h     = cmd_i.pp_idx[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp_prod = a_h * b_h;
  assign pp_ext  = {64'd0, pp_prod};

  always_comb begin
    case (cmd_i.pp_idx)
      2'd0:    pp_sh = pp_ext;
      2'd3:    pp_sh = pp_ext << 64;
      default: pp_sh = pp_ext << 32;
    endcase
  end

  // round half away from zero on the magnitude, then saturate
  assign rnd    = pacc_q + RND;
  assign rsh    = rnd >> FRAC_BITS;
  assign rmag   = (|rsh[127:62]) ? WIDE_MAX : rsh[63:0];
  assign prod_d = pneg_q ? 64'd0 - rmag : rmag;

  always_comb begin
    case (cmd_i.acc_tgt)
      TGT_DACC: acc_cur = dacc_q;
      TGT_TACC: acc_cur = tacc_q;
      TGT_DET:  acc_cur = det_q;
      default:  acc_cur = dacc_q;
    endcase
    cur_s = $signed({acc_cur[63], acc_cur});
    prd_s = $signed({prod_q[63], prod_q});
    case (cmd_i.acc_op)
      ACC_LOAD: acc_sum = prd_s;
      ACC_ADD:  acc_sum = cur_s + prd_s;
      ACC_SUB:  acc_sum = cur_s - prd_s;
      default:  acc_sum = prd_s;
    endcase
    if (acc_sum > POS_LIM) begin
      acc_new = WIDE_MAX;
    end else if (acc_sum < NEG_LIM) begin
      acc_new = 64'd0 - WIDE_MAX;
    end else begin
      acc_new = acc_sum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      opa_q <= rd_ext;
    end
    if (cmd_i.ld_b) begin
      ma_q   <= mag64(opa_q);
      mb_q   <= mag64(b_src);
      pneg_q <= opa_q[63] ^ b_src[63];
      pacc_q <= '0;
    end else if (cmd_i.mul_pp) begin
      pacc_q <= pacc_q + pp_sh;
    end
    if (cmd_i.mul_fin) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.acc_tgt)
        TGT_DACC: dacc_q <= acc_new;
        TGT_TACC: tacc_q <= acc_new;
        TGT_DET:  det_q  <= acc_new;
        default:  dacc_q <= acc_new;
      endcase
    end
  end

  // threshold register
  logic [THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign sts_o.det_small = mag64(det_q) <= {{(64 - THR_W){1'b0}}, thr_q};

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0] dnum_q;
  logic [63:0]      dd_q, r_q, q_q, num_s, num_m, r2, q_r, q_v, lim, res;
  logic             big_q, dneg_q, drun_q, dfin_q, done_q, inv_clip_q;
  logic [CNT_W-1:0] dcnt_q;
  logic             ge, big_n, inc, clip_v;
  logic [DATA_WIDTH-1:0] inv_q;

  assign num_s  = cmd_i.div_neg ? 64'd0 - tacc_q : tacc_q;
  assign num_m  = mag64(num_s);
  assign r2     = {r_q[62:0], dnum_q[NUM_W-1]};
  assign ge     = r2 >= dd_q;
  assign big_n  = big_q | (|q_q[63:60]);
  assign inc    = !big_q && ({r_q, 1'b0} >= {1'b0, dd_q});
  assign q_r    = q_q + {63'd0, inc};
  assign lim    = dneg_q ? LIM_NEG : LIM_POS;
  assign clip_v = big_q || (q_r > lim);
  assign q_v    = clip_v ? lim : q_r;
  assign res    = dneg_q ? 64'd0 - q_v : q_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dnum_q <= {num_m[61:0], {FRAC_BITS{1'b0}}};
      dd_q   <= mag64(det_q);
      dneg_q <= num_s[63] ^ det_q[63];
      r_q    <= '0;
      q_q    <= '0;
      big_q  <= 1'b0;
      dcnt_q <= CNT_W'(NUM_W - 1);
    end else if (drun_q) begin
      dnum_q <= dnum_q << 1;
      r_q    <= ge ? r2 - dd_q : r2;
      big_q  <= big_n;
      if (!big_q) begin
        q_q <= {q_q[62:0], ge & !big_n};
      end
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (dfin_q) begin
      inv_q      <= res[DATA_WIDTH-1:0];
      inv_clip_q <= clip_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drun_q <= 1'b0;
      dfin_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= dfin_q;
      dfin_q <= drun_q && (dcnt_q == '0);
      if (cmd_i.div_start) begin
        drun_q <= 1'b1;
      end else if (drun_q && (dcnt_q == '0)) begin
        drun_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done = done_q;
  assign inv_o          = inv_q;
  assign clip_o         = inv_clip_q;

endmodule
`default_nettype wire

FILE: rtl/core/mia_ctrl.sv
// Controller: load counter and sequencer for determinant, minors and divides.
`default_nettype none
module mia_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire mia_pkg::dp_sts_t   sts_i,
  output mia_pkg::dp_cmd_t        cmd_o,
  output logic                    valid_o,
  output logic                    singular_o,
  output logic                    last_o
);
  import mia_pkg::*;
`include "matrix4_inverse_adjugate_top_macros.svh"

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RDA  = 11'b000_0000_0010,
    S_RDB  = 11'b000_0000_0100,
    S_LDB  = 11'b000_0000_1000,
    S_MUL  = 11'b000_0001_0000,
    S_FIN  = 11'b000_0010_0000,
    S_ACC  = 11'b000_0100_0000,
    S_CHK  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_DIVW = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_e;

  state_e     state_q;
  logic [3:0] load_q, step_q, idx_q;
  logic [1:0] pp_q;
  logic       out_phase_q, sing_q;

  function automatic logic [1:0] skip(input logic [1:0] i, input logic [1:0] s);
    return (i < s) ? i : i + 2'd1;
  endfunction

  // minor being evaluated: skipped row sr, skipped column sc
  logic [1:0] sr, sc, ai, aj, bi, bj;
  logic [ADDR_W-1:0] a_addr, b_addr;
  bsel_e      b_sel;
  acc_tgt_e   tgt;
  acc_op_e    op;
  logic       det_step;

  assign sr = out_phase_q ? idx_q[1:0] : 2'd0;
  assign sc = out_phase_q ? idx_q[3:2] : idx_q[1:0];

  always_comb begin
    ai = 2'd0; aj = 2'd0; bi = 2'd0; bj = 2'd0;
    b_sel = BSEL_MEM; tgt = TGT_DACC; op = ACC_LOAD; det_step = 1'b0;
    case (step_q)
      4'd0: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd2; end
      4'd1: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd1; op = ACC_SUB; end
      4'd2: begin ai = 2'd0; aj = 2'd0; b_sel = BSEL_DACC; tgt = TGT_TACC; end
      4'd3: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd2; end
      4'd4: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd0; op = ACC_SUB; end
      4'd5: begin
        ai = 2'd0; aj = 2'd1; b_sel = BSEL_DACC; tgt = TGT_TACC; op = ACC_SUB;
      end
      4'd6: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd1; end
      4'd7: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd0; op = ACC_SUB; end
      4'd8: begin
        ai = 2'd0; aj = 2'd2; b_sel = BSEL_DACC; tgt = TGT_TACC; op = ACC_ADD;
      end
      default: begin
        // first-row expansion term of the determinant
        det_step = 1'b1;
        b_sel    = BSEL_TACC;
        tgt      = TGT_DET;
        if (idx_q == 4'd0) begin
          op = ACC_LOAD;
        end else begin
          op = idx_q[0] ? ACC_SUB : ACC_ADD;
        end
      end
    endcase
  end

  assign a_addr = det_step ? {2'd0, idx_q[1:0]} : {skip(ai, sr), skip(aj, sc)};
  assign b_addr = {skip(bi, sr), skip(bj, sc)};

  always_comb begin
    cmd_o         = '0;
    cmd_o.b_sel   = b_sel;
    cmd_o.acc_tgt = tgt;
    cmd_o.acc_op  = op;
    cmd_o.wr_addr = load_q;
    cmd_o.pp_idx  = pp_q;
    cmd_o.div_neg = idx_q[0] ^ idx_q[2];
    case (state_q)
      S_IDLE: cmd_o.wr_en = start_i;
      S_RDA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = a_addr;
      end
      S_RDB: begin
        cmd_o.ld_a    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = b_addr;
      end
      S_LDB:   cmd_o.ld_b = 1'b1;
      S_MUL:   cmd_o.mul_pp = 1'b1;
      S_FIN:   cmd_o.mul_fin = 1'b1;
      S_ACC:   cmd_o.acc_en = 1'b1;
      S_DIV:   cmd_o.div_start = 1'b1;
      default: cmd_o.wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_q      <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      pp_q        <= '0;
      out_phase_q <= 1'b0;
      sing_q      <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            load_q <= load_q + 4'd1;
            if (load_q == 4'd15) begin
              state_q     <= S_RDA;
              step_q      <= '0;
              idx_q       <= '0;
              out_phase_q <= 1'b0;
            end
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: state_q <= S_LDB;
        S_LDB: begin
          pp_q    <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          pp_q <= pp_q + 2'd1;
          if (pp_q == 2'd3) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: state_q <= S_ACC;
        S_ACC: begin
          if (!out_phase_q) begin
            if (step_q == 4'd9) begin
              step_q <= '0;
              if (idx_q == 4'd3) begin
                state_q <= S_CHK;
              end else begin
                idx_q   <= idx_q + 4'd1;
                state_q <= S_RDA;
              end
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= S_RDA;
            end
          end else if (step_q == 4'd8) begin
            state_q <= S_DIV;
          end else begin
            step_q  <= step_q + 4'd1;
            state_q <= S_RDA;
          end
        end
        S_CHK: begin
          sing_q <= sts_i.det_small;
          idx_q  <= '0;
          step_q <= '0;
          if (sts_i.det_small) begin
            state_q <= S_EMIT;
          end else begin
            out_phase_q <= 1'b1;
            state_q     <= S_RDA;
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (sts_i.div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (idx_q == 4'd15) begin
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 4'd1;
            if (!sing_q) begin
              step_q  <= '0;
              state_q <= S_RDA;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o     = state_q != S_IDLE;
  assign valid_o    = state_q == S_EMIT;
  assign last_o     = valid_o && (idx_q == 4'd15);
  assign singular_o = valid_o && sing_q;

  `MIA_ASSERT(a_last_to_idle, valid_o && last_o |=> state_q == S_IDLE)
  `MIA_ASSERT(a_busy_fell, $fell(busy_o) |-> $past(last_o))
  `MIA_ASSERT(a_load_done, start_i && !busy_o && load_q == 4'd15 |=> busy_o)
  `MIA_ASSERT_MSG(a_sing_burst, singular_o && !last_o |=> singular_o, "singular burst broken")

endmodule
`default_nettype wire

FILE: rtl/core/matrix4_inverse_adjugate_top.sv
// Top level of the 4x4 matrix inverse (adjugate over determinant) block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | start / busy         | element_i (one element, row-major)
//  result   | valid_o strobe       | inverse_element_o, singular_o,
//           |                      | saturated_o, last_o
//  config   | cfg_we_i             | cfg_data_i (singular threshold)
//
// A transfer in is any cycle with start high and busy low; busy stays low while
// the sixteen elements load. After the sixteenth transfer the block is busy
// until its last result. Every product goes through one shared 32x32 multiplier
// in four partial products. Determinant: 40 products. Each nonsingular result:
// 9 products plus a one-bit-per-cycle divide of 62+FRAC_BITS steps. A singular
// matrix gives its sixteen results on back-to-back cycles. Results are strobed
// for one cycle; the receiver cannot stall.
// Reset is asynchronous, active low, and clears threshold and load count.
`default_nettype none
module matrix4_inverse_adjugate_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [DATA_WIDTH-1:0]  element_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mia_pkg::THR_W-1:0]     cfg_data_i,
  output logic                               valid_o,
  output logic signed [DATA_WIDTH-1:0]       inverse_element_o,
  output logic                               singular_o,
  output logic                               saturated_o,
  output logic                               last_o
);
  import mia_pkg::*;

  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic [DATA_WIDTH-1:0] inv;
  logic                  clip;
  logic                  sing;

  mia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .valid_o    (valid_o),
    .singular_o (sing),
    .last_o     (last_o)
  );

  mia_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .element_i  (element_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .inv_o      (inv),
    .clip_o     (clip)
  );

  // a singular matrix returns zeros with no clip flag
  assign singular_o        = sing;
  assign inverse_element_o = sing ? '0 : inv;
  assign saturated_o       = valid_o && !sing && clip;

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_MATRICES = 15;

  localparam longint WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [mia_pkg::THR_W-1:0] THR_MAX = '1;

  // Kinds of random element content.
  typedef enum int {
    EL_UNIT, EL_SMALL, EL_FULL, EL_EDGE
  } elem_kind_e;

  typedef struct {
    logic signed [DW-1:0] value;
    bit                   singular;
    bit                   clipped;
    bit                   last;
  } inv_result_t;

  // Inverse predictor plus the queue of expected result transfers.
  class inverse_scoreboard;
    longint               mat[16];
    int unsigned          fill;
    logic [30:0]          threshold;
    inv_result_t          pending_q[$];
    int                   errors;

    function new();
      fill = 0;
      threshold = '0;
      errors = 0;
    endfunction

    function longint clip_wide(longint v);
      if (v > WIDE_LIM) return WIDE_LIM;
      if (v < -WIDE_LIM) return -WIDE_LIM;
      return v;
    endfunction

    function logic [63:0] mag(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Product rounded half away from zero, clipped to the wide range.
    function longint qmul(longint x, longint y);
      logic [127:0] p;
      longint r;
      p = {64'd0, mag(x)} * {64'd0, mag(y)};
      p = (p + (128'd1 << (FB - 1))) >> FB;
      r = (p > 128'(WIDE_LIM)) ? WIDE_LIM : longint'(p[63:0]);
      return ((x < 0) != (y < 0)) ? -r : r;
    endfunction

    function longint cross2(longint a, longint b, longint c, longint d);
      return clip_wide(qmul(a, d) - qmul(b, c));
    endfunction

    // 3x3 minor with row sr and column sc removed.
    function longint minor3(int sr, int sc);
      longint a[3][3];
      longint t;
      int i, j;
      i = 0;
      for (int r = 0; r < 4; r++) begin
        if (r != sr) begin
          j = 0;
          for (int c = 0; c < 4; c++) begin
            if (c != sc) begin
              a[i][j] = mat[r*4+c];
              j++;
            end
          end
          i++;
        end
      end
      t = clip_wide(qmul(a[0][0], cross2(a[1][1], a[1][2], a[2][1], a[2][2]))
                  - qmul(a[0][1], cross2(a[1][0], a[1][2], a[2][0], a[2][2])));
      return clip_wide(t + qmul(a[0][2], cross2(a[1][0], a[1][1], a[2][0], a[2][1])));
    endfunction

    // round(num * 2^FB / den) saturated to the output width.
    function void qdiv(longint num, longint den, output logic signed [DW-1:0] val,
                       output bit clip);
      logic [127:0] n, d, q, rm, lim;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = {64'd0, mag(num)} << FB;
      d = {64'd0, mag(den)};
      q = n / d;
      rm = n % d;
      if (2 * rm >= d) q++;
      lim = neg ? (128'd1 << (DW - 1)) : (128'd1 << (DW - 1)) - 1;
      clip = q > lim;
      if (clip) q = lim;
      val = neg ? DW'(-q) : DW'(q);
    endfunction

    // Note an accepted element; the sixteenth one queues the whole inverse.
    function void note_element(logic signed [DW-1:0] el);
      longint det, cof;
      inv_result_t res;
      bit sing;
      mat[fill] = longint'(el);
      if (fill != 15) begin
        fill++;
        return;
      end
      fill = 0;
      det = 0;
      for (int k = 0; k < 4; k++) begin
        cof = qmul(mat[k], minor3(0, k));
        det = clip_wide((k % 2 == 1) ? det - cof : det + cof);
      end
      sing = mag(det) <= 64'(threshold);
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          res.value = '0;
          res.clipped = 0;
          res.singular = sing;
          res.last = (r == 3 && c == 3);
          if (!sing) begin
            cof = minor3(c, r);
            if ((r + c) % 2 == 1) cof = -cof;
            qdiv(cof, det, res.value, res.clipped);
          end
          pending_q.push_back(res);
        end
      end
    endfunction

    function void check_result(logic signed [DW-1:0] val, bit sing, bit sat, bit lst);
      inv_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value=%h singular=%b saturated=%b last=%b",
                 $realtime, val, sing, sat, lst);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (val !== e.value) begin
        $display("%0t: inverse_element expected %h actual %h", $realtime, e.value, val);
        errors++;
      end
      if (sing !== e.singular) begin
        $display("%0t: singular expected %b actual %b", $realtime, e.singular, sing);
        errors++;
      end
      if (sat !== e.clipped) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.clipped, sat);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %b actual %b", $realtime, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic signed [DW-1:0]          element_i;
  logic                          cfg_we_i;
  logic [mia_pkg::THR_W-1:0]     cfg_data_i;
  logic                          valid_o;
  logic signed [DW-1:0]          inverse_element_o;
  logic                          singular_o;
  logic                          saturated_o;
  logic                          last_o;

  inverse_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit allow_gaps = 1;

  matrix4_inverse_adjugate_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .element_i        (element_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .valid_o          (valid_o),
    .inverse_element_o(inverse_element_o),
    .singular_o       (singular_o),
    .saturated_o      (saturated_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are strobed for one cycle and cannot be held off: check each one
  // at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result(inverse_element_o, singular_o, saturated_o, last_o);
  end

  // Watchdog: a run that hangs fails here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix4_inverse_adjugate_top verification failed");
      $finish;
    end
  end

  // One element transfer. Unless the task itself opens a random gap (start low),
  // start stays high on return so back-to-back transfers never drop it.
  task automatic send_element(logic signed [DW-1:0] el);
    start     <= 1'b1;
    element_i <= el;
    do @(posedge clk_i); while (busy);
    sb.note_element(el);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Threshold writes only with the block idle: drain, then let it settle.
  task automatic write_threshold(logic [mia_pkg::THR_W-1:0] thr);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.threshold = thr;
  endtask

  function automatic logic signed [DW-1:0] pick_element(elem_kind_e kind);
    case (kind)
      EL_UNIT:  return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      EL_SMALL: return DW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      EL_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return 32'sh0000_0001;
          default: return -32'sh0000_0001;
        endcase
      end
      default: return DW'($urandom);
    endcase
  endfunction

  // Random matrices: half are a +-1.0 diagonal with random small off terms,
  // the rest mixed element kinds or entirely full-range random entries.
  task automatic send_random_matrix();
    elem_kind_e kind;
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < 16; i++) begin
      if (style == 0)
        kind = elem_kind_e'($urandom_range(0, 3));
      else if (style == 1)
        kind = EL_FULL;
      else
        kind = (i % 5 == 0) ? EL_UNIT : EL_SMALL;
      send_element(pick_element(kind));
    end
    end_burst();
  endtask

  initial begin
    logic signed [DW-1:0] el;
    start      = 1'b0;
    element_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity gives exact 1.0 on the diagonal.
    for (int i = 0; i < 16; i++)
      send_element((i % 5 == 0) ? 32'sh0001_0000 : '0);
    end_burst();
    // Tiny diagonal: products round to a zero determinant, so it is singular.
    for (int i = 0; i < 16; i++)
      send_element((i % 5 == 0) ? 32'sh0000_0100 : '0);
    end_burst();
    // Extremes of the element range; an all-zero matrix is singular at
    // threshold zero.
    for (int i = 0; i < 16; i++) begin
      el = (i % 5 == 0) ? ((i % 2 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000) : '0;
      send_element(el);
    end
    end_burst();
    for (int i = 0; i < 16; i++) send_element('0);
    end_burst();

    // Random phases across threshold settings, extremes included.
    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      case (m)
        4:  write_threshold(THR_MAX);
        6:  write_threshold(mia_pkg::THR_W'($urandom_range(1, 1 << 20)));
        10: write_threshold(mia_pkg::THR_W'($urandom));
        13: write_threshold('0);
        default: ;
      endcase
      if (m >= RANDOM_MATRICES - 3) allow_gaps = 0;
      send_random_matrix();
    end

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("matrix4_inverse_adjugate_top verification clean");
    end else begin
      $display("matrix4_inverse_adjugate_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
